FILE: src/lwtlv_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lwtlv_pkg;

	// Parse position inside one element
	typedef enum logic [2:0] {
		PH_TYPE  = 3'd0,
		PH_ID_A  = 3'd1,
		PH_ID_B  = 3'd2,
		PH_LEN_A = 3'd3,
		PH_LEN_B = 3'd4,
		PH_LEN_C = 3'd5,
		PH_VALUE = 3'd6
	} phase_t;

	// Result kinds
	localparam logic [1:0] KIND_HDR_BYTE = 2'd0;
	localparam logic [1:0] KIND_HDR_DONE = 2'd1;
	localparam logic [1:0] KIND_VALUE    = 2'd2;
	localparam logic [1:0] KIND_SKIP     = 2'd3;

	// Element types from the two top bits of the type byte
	localparam logic [1:0] TYPE_OBJ_INST = 2'd0;
	localparam logic [1:0] TYPE_RES_INST = 2'd1;
	localparam logic [1:0] TYPE_MULTI    = 2'd2;
	localparam logic [1:0] TYPE_RES      = 2'd3;

	// Error codes
	localparam logic [1:0] ERR_NONE   = 2'd0;
	localparam logic [1:0] ERR_TYPE   = 2'd1;
	localparam logic [1:0] ERR_PARENT = 2'd2;
	localparam logic [1:0] ERR_TRUNC  = 2'd3;

	localparam int LEN_W = 24;
	localparam int ID_W  = 16;

	typedef struct packed {
		logic [1:0]       kind;
		logic [1:0]       elem_type;
		logic [ID_W-1:0]  elem_id;
		logic [LEN_W-1:0] elem_length;
		logic [1:0]       level;
		logic [7:0]       value_byte;
		logic             value_last;
		logic [1:0]       error_code;
		logic             message_done;
	} result_t;

	function automatic logic is_container(input logic [1:0] t);
		return (t == TYPE_OBJ_INST) || (t == TYPE_MULTI);
	endfunction

endpackage

`default_nettype wire

FILE: src/lwm2m_tlv_stream_parser_top.sv
`timescale 1ns / 1ps
`default_nettype none

// LwM2M TLV stream parser.
// Input channel s_*: one message byte per transfer, s_tlast on the final byte.
// Output channel m_*: exactly one result per input byte, in order; m_tuser holds
// the result kind, m_tlast marks the result of the final message byte.
// cfg_we/cfg_wdata set the level of top-level elements; write it only while the
// block is idle.
// A byte accepted on s_* is captured in the input register, and its result
// is then registered in the result register and shown on m_*. Throughput:
// one byte per cycle while the receiver takes results, set by the single pass of
// header/length logic between the input register and the result register.
// When the receiver stalls, the result register holds and the input register
// still takes one more byte; after that s_tready drops until m_tready returns.
// Reset clears the parse state, both pipeline valids and start_level (to 0).
// After every final byte the parse state returns to its reset value.
module lwm2m_tlv_stream_parser_top
	import lwtlv_pkg::*;
#(
	parameter int MAX_DEPTH = 3
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
	input  wire logic        s_tlast,   // last_byte
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [55:0]      m_tdata,   // elem_type, elem_id, elem_length, level,
	                                    // value_byte, value_last, error_code, pad
	output logic [1:0]       m_tuser,   // kind
	output logic             m_tlast,   // message_done
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_wdata  // start_level
);

	localparam int DW = $clog2(MAX_DEPTH + 1);
	localparam int IW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
	localparam int LW = DW + 2;

	// Configuration
	logic [1:0] start_level_q;

	// Input register
	logic       s1_valid_q;
	logic [7:0] byte_s1;
	logic       last_s1;

	// Parse state
	phase_t           phase_q,  phase_n;
	logic [7:0]       hold_q,   hold_n;
	logic [ID_W-1:0]  id_q,     id_n;
	logic [LEN_W-1:0] len_q,    len_n;
	logic [LEN_W-1:0] vleft_q,  vleft_n;
	logic [LEN_W-1:0] stack_q [MAX_DEPTH];
	logic [LEN_W-1:0] stack_n [MAX_DEPTH];
	logic [LEN_W-1:0] stack_dec [MAX_DEPTH];
	logic [DW-1:0]    depth_q,  depth_n;
	logic             err_seen_q, err_seen_n;

	// Result register
	logic    out_valid_q;
	result_t res_q, res;

	logic adv, proc_go;

	// Pipeline flow
	assign adv      = !out_valid_q || m_tready;
	assign proc_go  = s1_valid_q && adv;
	assign s_tready = !s1_valid_q || adv;

	// Config register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_level_q <= 2'd0;
		end else if (cfg_we) begin
			start_level_q <= cfg_wdata;
		end
	end

	// Capture input transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (s_tready) begin
			s1_valid_q <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	// Helpers on the current state
	logic [1:0]       start_c;
	logic [LW-1:0]    lvl_full;
	logic [IW-1:0]    top_idx;
	logic             depth_ok;
	logic [LEN_W-1:0] top_rem, top_rem_dec;
	logic [DW-1:0]    pop_depth;
	logic [1:0]       lt;
	logic [1:0]       t_in;
	logic             type_good;

	always_comb begin
		start_c  = (start_level_q == 2'd3) ? 2'd2 : start_level_q;
		lvl_full = LW'(start_c) + LW'(depth_q);
		top_idx  = IW'(depth_q - 1'b1);
		depth_ok = (depth_q != '0) && (depth_q <= DW'(MAX_DEPTH));
		top_rem  = stack_q[top_idx];
		lt       = hold_q[4:3];
		t_in     = byte_s1[7:6];
		if (lvl_full == LW'(0)) begin
			type_good = (t_in == TYPE_OBJ_INST);
		end else if (lvl_full == LW'(1)) begin
			type_good = (t_in != TYPE_OBJ_INST);
		end else begin
			type_good = (t_in == TYPE_RES_INST);
		end
	end

	// Charge this byte to every open container
	always_comb begin
		for (int i = 0; i < MAX_DEPTH; i++) begin
			if ((DW'(i) < depth_q) && (stack_q[i] != '0)) begin
				stack_dec[i] = stack_q[i] - 1'b1;
			end else begin
				stack_dec[i] = stack_q[i];
			end
		end
		top_rem_dec = stack_dec[top_idx];
	end

	// Close every exhausted container from the top down
	always_comb begin
		pop_depth = '0;
		for (int i = 0; i < MAX_DEPTH; i++) begin
			if ((DW'(i) < depth_q) && (stack_dec[i] != '0)) begin
				pop_depth = DW'(i + 1);
			end
		end
	end

	// Decode one byte
	always_comb begin
		logic complete;
		logic push;
		logic [LEN_W-1:0] vl_dec;

		complete   = 1'b0;
		push       = 1'b0;
		vl_dec     = (vleft_q != '0) ? vleft_q - 1'b1 : vleft_q;
		phase_n    = phase_q;
		hold_n     = hold_q;
		id_n       = id_q;
		len_n      = len_q;
		vleft_n    = vleft_q;
		depth_n    = depth_q;
		err_seen_n = err_seen_q;
		for (int i = 0; i < MAX_DEPTH; i++) begin
			stack_n[i] = stack_q[i];
		end
		res              = '0;
		res.message_done = last_s1;

		if (err_seen_q) begin
			res.kind = KIND_SKIP;
		end else begin
			res.level = lvl_full[1:0];
			if ((phase_q != PH_VALUE) && depth_ok && (top_rem == '0)) begin
				res.error_code = ERR_PARENT;
			end else begin
				case (phase_q)
					PH_TYPE: begin
						if (!type_good || (is_container(t_in) && depth_q >= DW'(MAX_DEPTH))) begin
							res.error_code = ERR_TYPE;
						end else begin
							hold_n  = byte_s1;
							id_n    = '0;
							// inline length when no extra length bytes follow
							len_n   = (byte_s1[4:3] == 2'd0) ? LEN_W'(byte_s1[2:0]) : '0;
							phase_n = PH_ID_A;
						end
					end
					PH_VALUE: begin
						res.kind       = KIND_VALUE;
						res.value_byte = byte_s1;
						vleft_n        = vl_dec;
						res.value_last = (vl_dec == '0);
					end
					PH_ID_A, PH_ID_B: begin
						id_n = {id_q[7:0], byte_s1};
						if (phase_q == PH_ID_A && hold_q[5]) begin
							phase_n = PH_ID_B;
						end else if (lt == 2'd0) begin
							complete = 1'b1;
						end else begin
							phase_n = PH_LEN_A;
						end
					end
					PH_LEN_A, PH_LEN_B, PH_LEN_C: begin
						len_n = {len_q[LEN_W-9:0], byte_s1};
						if ((phase_q == PH_LEN_A && lt <= 2'd1) ||
						    (phase_q == PH_LEN_B && lt <= 2'd2) ||
						    (phase_q == PH_LEN_C)) begin
							complete = 1'b1;
						end else begin
							phase_n = phase_t'(phase_q + 3'd1);
						end
					end
					default: begin
						phase_n = PH_TYPE;
					end
				endcase
			end

			if (res.error_code != ERR_NONE) begin
				res.kind   = KIND_SKIP;
				res.level  = 2'd0;
				err_seen_n = 1'b1;
			end else begin
				for (int i = 0; i < MAX_DEPTH; i++) begin
					stack_n[i] = stack_dec[i];
				end
				res.elem_type   = hold_n[7:6];
				res.elem_id     = id_n;
				res.elem_length = len_n;
				if (complete) begin
					if (depth_ok && (len_n > top_rem_dec)) begin
						res            = '0;
						res.kind       = KIND_SKIP;
						res.error_code = ERR_PARENT;
						res.message_done = last_s1;
						err_seen_n     = 1'b1;
					end else begin
						res.kind = KIND_HDR_DONE;
						if (len_n == '0) begin
							phase_n = PH_TYPE;
							depth_n = pop_depth;
						end else if (is_container(hold_n[7:6])) begin
							push    = (depth_q < DW'(MAX_DEPTH));
							depth_n = depth_q + 1'b1;
							phase_n = PH_TYPE;
						end else begin
							vleft_n = len_n;
							phase_n = PH_VALUE;
						end
					end
				end else if (res.kind == KIND_VALUE && res.value_last) begin
					phase_n = PH_TYPE;
					depth_n = pop_depth;
				end
				// open a new container level
				for (int i = 0; i < MAX_DEPTH; i++) begin
					if (push && DW'(i) == depth_q) begin
						stack_n[i] = len_n;
					end
				end
				if (last_s1 && res.error_code == ERR_NONE &&
				    (phase_n != PH_TYPE || depth_n != '0)) begin
					res.error_code = ERR_TRUNC;
				end
			end
		end
	end

	// Advance parse state; drop it all after the final byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_TYPE;
			hold_q     <= '0;
			id_q       <= '0;
			len_q      <= '0;
			vleft_q    <= '0;
			depth_q    <= '0;
			err_seen_q <= 1'b0;
			for (int i = 0; i < MAX_DEPTH; i++) begin
				stack_q[i] <= '0;
			end
		end else if (proc_go) begin
			if (last_s1) begin
				phase_q    <= PH_TYPE;
				hold_q     <= '0;
				id_q       <= '0;
				len_q      <= '0;
				vleft_q    <= '0;
				depth_q    <= '0;
				err_seen_q <= 1'b0;
				for (int i = 0; i < MAX_DEPTH; i++) begin
					stack_q[i] <= '0;
				end
			end else begin
				phase_q    <= phase_n;
				hold_q     <= hold_n;
				id_q       <= id_n;
				len_q      <= len_n;
				vleft_q    <= vleft_n;
				depth_q    <= depth_n;
				err_seen_q <= err_seen_n;
				for (int i = 0; i < MAX_DEPTH; i++) begin
					stack_q[i] <= stack_n[i];
				end
			end
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= s1_valid_q;
		end
	end

	always_ff @(posedge clk) begin
		if (proc_go) begin
			res_q <= res;
		end
	end

	// Drive output transfer
	assign m_tvalid = out_valid_q;
	assign m_tuser  = res_q.kind;
	assign m_tlast  = res_q.message_done;
	assign m_tdata  = {1'b0, res_q.error_code, res_q.value_last, res_q.value_byte,
	                   res_q.level, res_q.elem_length, res_q.elem_id, res_q.elem_type};

	// Checks
	a_depth_bound: assert property (@(posedge clk) disable iff (!arst_n)
		depth_q <= DW'(MAX_DEPTH))
		else $error("nesting depth beyond limit");

	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		proc_go && last_s1 |=> depth_q == '0 && phase_q == PH_TYPE && !err_seen_q)
		else $error("state not cleared after final byte");

	a_err_skip: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (res_q.error_code == ERR_TYPE || res_q.error_code == ERR_PARENT)
		|-> res_q.kind == KIND_SKIP)
		else $error("detected error without skip kind");

	a_vlast_kind: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && res_q.value_last |-> res_q.kind == KIND_VALUE)
		else $error("value_last outside a value byte");

endmodule

`default_nettype wire
